// ===== rtl/sml_pkg.sv =====
package sml_pkg;

   // fixed field widths
   localparam int LABEL_W  = 3;
   localparam int KERNEL_W = 6;

   // configuration reset value
   localparam logic [KERNEL_W-1:0] KERNEL_RESET = KERNEL_W'(9);

   // defaults for the top level parameters
   localparam int DEF_MAX_WINDOW  = 63;
   localparam int DEF_NUM_CLASSES = 7;

   // wide enough for any window length in the parameter range
   localparam int WIDE_W = 8;

   typedef logic [LABEL_W-1:0] label_type;

endpackage

// ===== rtl/sml_if.sv =====
interface sml_req_if;
   import sml_pkg::*;

   logic      valid;
   logic      ready;
   label_type label_in;
   logic      last_in;

   modport source (output valid, output label_in, output last_in, input ready);
   modport sink (input valid, input label_in, input last_in, output ready);
endinterface

interface sml_rsp_if;
   import sml_pkg::*;

   logic      valid;
   logic      ready;
   label_type label_out;
   logic      last_out;

   modport source (output valid, output label_out, output last_out, input ready);
   modport sink (input valid, input label_out, input last_out, output ready);
endinterface

// ===== rtl/sml_ram.sv =====
module sml_ram #(
   parameter int WIDTH = 3,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/sliding_majority_label_filter.sv =====
// path: a label is registered into stage 1, and its result into the output register
// throughput: one label transaction per cycle while the output is not stalled; each
//   history ram copy takes one write and one registered read per transaction
// end of sequence: the flush emits up to (K-1)/2 held zeros, one per cycle while
//   the output is ready, after the last label's own result if any, stalling the input
// reset: kernel size 9, empty sequence; history entries are only read after written
module sliding_majority_label_filter #(
   parameter int MAX_WINDOW  = sml_pkg::DEF_MAX_WINDOW,
   parameter int NUM_CLASSES = sml_pkg::DEF_NUM_CLASSES
) (
   input  logic                          clock,
   input  logic                          reset,
   sml_req_if.sink                       req_port,
   sml_rsp_if.source                     rsp_port,
   input  logic                          csr_write_en,
   input  logic [sml_pkg::KERNEL_W-1:0]  csr_write_data
);
   import sml_pkg::*;

   // history ram holds one spare entry so that the label leaving a full
   // window never shares an address with the label being written
   localparam int DEPTH    = MAX_WINDOW + 1;
   localparam int AW       = $clog2(DEPTH);
   localparam int KW       = $clog2(MAX_WINDOW + 1);
   localparam int FW       = $clog2(MAX_WINDOW + 2);
   localparam int FILL_MAX = MAX_WINDOW + 1;

   typedef struct packed {
      label_type     label;
      logic          last;
      logic          has_main;     // a window centers on a position this transaction
      logic          full;         // window complete, vote applies
      logic          leave_en;     // oldest label drops out of the counts
      logic          self_center;  // window center is the new label itself
      logic [KW-1:0] pend;         // held zeros emitted on flush
      logic [KW-1:0] thresh;       // majority threshold k/2+1
   } s1_type;

   // ---------------------------------------------------------------
   // configuration and effective window geometry
   // ---------------------------------------------------------------
   logic [KERNEL_W-1:0] kernel_ff;
   logic [WIDE_W-1:0]   k_wide;
   logic [KW-1:0]       k_eff;
   logic [KW-1:0]       d_off;
   logic [KW-1:0]       thresh;

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_ff <= KERNEL_RESET;
      end else if (csr_write_en) begin
         kernel_ff <= csr_write_data;
      end
   end

   always_comb begin
      k_wide = WIDE_W'(kernel_ff);
      if (k_wide == '0) begin
         k_wide = WIDE_W'(1);
      end else if (k_wide > WIDE_W'(MAX_WINDOW)) begin
         k_wide = WIDE_W'(MAX_WINDOW);
      end
      k_eff  = k_wide[KW-1:0];
      // center offset from the newest label
      d_off  = (k_eff - KW'(1)) >> 1;
      thresh = (k_eff >> 1) + KW'(1);
   end

   // ---------------------------------------------------------------
   // stage 0: accept, write history, issue center and leaving reads
   // ---------------------------------------------------------------
   logic          accept;
   logic          s1_valid_ff;
   logic          s1_valid_in;
   logic          s1_advance;
   s1_type        s1_ff;
   s1_type        s1_in;
   logic [AW-1:0] wp_ff;
   logic [AW-1:0] wp_in;
   logic [FW-1:0] fill_ff;
   logic [FW-1:0] fill_in;
   logic [FW-1:0] fill_new;
   label_type     label_clean;
   logic [AW:0]   wp_ext;
   logic [AW:0]   center_off;
   logic [AW:0]   leave_off;
   logic [AW-1:0] center_addr;
   logic [AW-1:0] leave_addr;

   assign req_port.ready = !s1_valid_ff || s1_advance;
   assign accept         = req_port.valid && req_port.ready;

   always_comb begin
      // out of range labels count as background
      label_clean = req_port.label_in;
      if (int'(req_port.label_in) >= NUM_CLASSES) begin
         label_clean = '0;
      end

      fill_new = (fill_ff == FW'(FILL_MAX)) ? fill_ff : fill_ff + FW'(1);

      // circular addressing, newest label at wp_ff
      wp_ext     = {1'b0, wp_ff};
      center_off = (AW + 1)'(d_off);
      leave_off  = (AW + 1)'(k_eff);
      if (wp_ext >= center_off) begin
         center_addr = AW'(wp_ext - center_off);
      end else begin
         center_addr = AW'(wp_ext + (AW + 1)'(DEPTH) - center_off);
      end
      if (wp_ext >= leave_off) begin
         leave_addr = AW'(wp_ext - leave_off);
      end else begin
         leave_addr = AW'(wp_ext + (AW + 1)'(DEPTH) - leave_off);
      end

      wp_in   = wp_ff;
      fill_in = fill_ff;
      if (accept) begin
         wp_in   = (wp_ff == AW'(DEPTH - 1)) ? '0 : wp_ff + AW'(1);
         fill_in = req_port.last_in ? '0 : fill_new;
      end
      if (csr_write_en) begin
         fill_in = '0;
      end

      s1_in.label       = label_clean;
      s1_in.last        = req_port.last_in;
      s1_in.has_main    = fill_new > FW'(d_off);
      s1_in.full        = fill_new >= FW'(k_eff);
      s1_in.leave_en    = fill_new > FW'(k_eff);
      s1_in.self_center = (d_off == '0);
      s1_in.pend        = (fill_new < FW'(d_off)) ? fill_new[KW-1:0] : d_off;
      s1_in.thresh      = thresh;

      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff       <= '0;
         fill_ff     <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         wp_ff       <= wp_in;
         fill_ff     <= fill_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
   end

   // two copies of the history so the center and leaving labels are read in the same cycle
   label_type center_rd;
   label_type leave_rd;

   sml_ram #(
      .WIDTH (LABEL_W),
      .DEPTH (DEPTH)
   ) u_center_ram (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (wp_ff),
      .wr_data (label_clean),
      .rd_en   (accept),
      .rd_addr (center_addr),
      .rd_data (center_rd)
   );

   sml_ram #(
      .WIDTH (LABEL_W),
      .DEPTH (DEPTH)
   ) u_leave_ram (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (wp_ff),
      .wr_data (label_clean),
      .rd_en   (accept),
      .rd_addr (leave_addr),
      .rd_data (leave_rd)
   );

   // ---------------------------------------------------------------
   // stage 1: incremental class counts and majority vote
   // ---------------------------------------------------------------
   logic [KW-1:0] counts_ff  [NUM_CLASSES];
   logic [KW-1:0] counts_new [NUM_CLASSES];
   label_type     center_label;
   label_type     maj_class;
   logic          maj_found;
   label_type     vote;
   logic          job_has_out;
   logic          out_free;

   always_comb begin
      center_label = s1_ff.self_center ? s1_ff.label : center_rd;
      for (int c = 0; c < NUM_CLASSES; c++) begin
         counts_new[c] = counts_ff[c]
                         + KW'(int'(s1_ff.label) == c)
                         - KW'(s1_ff.leave_en && (int'(leave_rd) == c));
      end
      // background never wins the vote
      maj_found = 1'b0;
      maj_class = '0;
      for (int c = 1; c < NUM_CLASSES; c++) begin
         if (counts_new[c] >= s1_ff.thresh) begin
            maj_found = 1'b1;
            maj_class = LABEL_W'(c);
         end
      end
      if (!s1_ff.full) begin
         vote = '0;
      end else if (maj_found) begin
         vote = maj_class;
      end else begin
         vote = center_label;
      end
   end

   // a last label always yields at least one result
   assign job_has_out = s1_ff.has_main || s1_ff.last;

   always_ff @(posedge clock) begin
      if (reset || csr_write_en) begin
         for (int c = 0; c < NUM_CLASSES; c++) begin
            counts_ff[c] <= '0;
         end
      end else if (s1_advance) begin
         for (int c = 0; c < NUM_CLASSES; c++) begin
            counts_ff[c] <= s1_ff.last ? '0 : counts_new[c];
         end
      end
   end

   // ---------------------------------------------------------------
   // output register and flush sequencer
   // ---------------------------------------------------------------
   logic          out_valid_ff;
   logic          out_valid_in;
   label_type     out_label_ff;
   label_type     out_label_in;
   logic          out_last_ff;
   logic          out_last_in;
   logic [KW-1:0] zeros_left_ff;
   logic [KW-1:0] zeros_left_in;
   logic          slot_open;

   assign slot_open  = !out_valid_ff || rsp_port.ready;
   assign out_free   = slot_open && (zeros_left_ff == '0);
   assign s1_advance = s1_valid_ff && (!job_has_out || out_free);

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_label_in  = out_label_ff;
      out_last_in   = out_last_ff;
      zeros_left_in = zeros_left_ff;
      if (out_valid_ff && rsp_port.ready) begin
         out_valid_in = 1'b0;
      end
      if ((zeros_left_ff != '0) && slot_open) begin
         // drain held positions of a flushed sequence
         out_valid_in  = 1'b1;
         out_label_in  = '0;
         out_last_in   = (zeros_left_ff == KW'(1));
         zeros_left_in = zeros_left_ff - KW'(1);
      end else if (s1_advance && job_has_out) begin
         out_valid_in = 1'b1;
         if (s1_ff.has_main) begin
            out_label_in  = vote;
            out_last_in   = s1_ff.last && (s1_ff.pend == '0);
            zeros_left_in = s1_ff.last ? s1_ff.pend : '0;
         end else begin
            out_label_in  = '0;
            out_last_in   = (s1_ff.pend == KW'(1));
            zeros_left_in = s1_ff.pend - KW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         zeros_left_ff <= '0;
      end else begin
         out_valid_ff  <= out_valid_in;
         zeros_left_ff <= zeros_left_in;
      end
   end

   always_ff @(posedge clock) begin
      out_label_ff <= out_label_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_port.valid     = out_valid_ff;
   assign rsp_port.label_out = out_label_ff;
   assign rsp_port.last_out  = out_last_ff;

endmodule

// ===== tb/sml_label_checker.sv =====
`timescale 1ns / 100ps

module sml_label_checker #(
   parameter int MAX_WINDOW  = sml_pkg::DEF_MAX_WINDOW,
   parameter int NUM_CLASSES = sml_pkg::DEF_NUM_CLASSES
) (
   input  logic                         clock,
   input  logic                         reset,
   sml_req_if                           req_mon,
   sml_rsp_if                           rsp_mon,
   input  logic                         csr_write_en,
   input  logic [sml_pkg::KERNEL_W-1:0] csr_write_data,
   output int                           fail_count,
   output int                           pending_count,
   output int                           checked_count
);
   import sml_pkg::*;

   typedef struct packed {
      label_type label;
      logic      last;
   } filtered_label_type;

   logic [KERNEL_W-1:0] kernel_reg;
   label_type           history [MAX_WINDOW];
   int                  seq_len;
   filtered_label_type  filtered_q [$];
   int                  errors  = 0;
   int                  checked = 0;

   function automatic int window_len();
      if (kernel_reg == 0) return 1;
      if (kernel_reg > MAX_WINDOW) return MAX_WINDOW;
      return int'(kernel_reg);
   endfunction

   function automatic void clear_stream();
      foreach (history[i]) history[i] = '0;
      seq_len = 0;
   endfunction

   function automatic label_type majority_label(input int k, input int center);
      int        votes [NUM_CLASSES];
      label_type winner;
      winner = history[center];
      foreach (votes[c]) votes[c] = 0;
      for (int i = 0; i < k; i++) votes[history[i]]++;
      for (int c = 1; c < NUM_CLASSES; c++) begin
         if (votes[c] >= k / 2 + 1) winner = label_type'(c);
      end
      return winner;
   endfunction

   // queue up every filtered label that one input label releases
   function automatic void predict_filtered(input label_type lab_in, input logic last_in);
      int                 k;
      int                 lag;
      int                 flushed;
      int                 emitted;
      label_type          lab;
      filtered_label_type res;
      k       = window_len();
      lag     = k - 1 - k / 2;
      emitted = 0;
      lab     = (lab_in >= NUM_CLASSES) ? label_type'(0) : lab_in;
      for (int i = MAX_WINDOW - 1; i > 0; i--) history[i] = history[i - 1];
      history[0] = lab;
      if (seq_len < MAX_WINDOW) seq_len++;
      if (seq_len > lag) begin
         res.label = (seq_len >= k) ? majority_label(k, lag) : label_type'(0);
         res.last  = 1'b0;
         filtered_q.push_back(res);
         emitted++;
      end
      if (last_in) begin
         flushed = (seq_len < lag) ? seq_len : lag;
         res.label = '0;
         res.last  = 1'b0;
         repeat (flushed) begin
            filtered_q.push_back(res);
            emitted++;
         end
         if (emitted > 0) begin
            res = filtered_q.pop_back();
            res.last = 1'b1;
            filtered_q.push_back(res);
         end
         clear_stream();
      end
   endfunction

   always @(posedge clock) begin
      filtered_label_type want;
      if (reset) begin
         kernel_reg = KERNEL_RESET;
         clear_stream();
         filtered_q.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (filtered_q.size() == 0) begin
               $display("%0t: unexpected transaction, expected none, got label %0d last %0b",
                        $time, rsp_mon.label_out, rsp_mon.last_out);
               errors++;
            end else begin
               want = filtered_q.pop_front();
               checked++;
               if (rsp_mon.label_out !== want.label) begin
                  $display("%0t: label_out expected %0d, got %0d",
                           $time, want.label, rsp_mon.label_out);
                  errors++;
               end
               if (rsp_mon.last_out !== want.last) begin
                  $display("%0t: last_out expected %0b, got %0b",
                           $time, want.last, rsp_mon.last_out);
                  errors++;
               end
            end
         end
         if (csr_write_en) begin
            kernel_reg = csr_write_data;
            clear_stream();
         end
         if (req_mon.valid && req_mon.ready)
            predict_filtered(req_mon.label_in, req_mon.last_in);
      end
      fail_count    <= errors;
      pending_count <= filtered_q.size();
      checked_count <= checked;
   end

endmodule

// ===== tb/sliding_majority_label_filter_tb.sv =====
`timescale 1ns / 100ps

module sliding_majority_label_filter_tb;
   import sml_pkg::*;

   // idle cycles after the last expected result before touching the kernel register;
   // covers the two-stage pipe behind labels that release nothing
   localparam int SETTLE_CYCLES = 12;
   // quiet cycles at the end so a stray extra transaction still gets caught
   localparam int DRAIN_CYCLES  = 40;
   // receiver hold-off, long enough to back the block up into its input
   localparam int HOLD_CYCLES   = 100;

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_write_en;
   logic [KERNEL_W-1:0] csr_write_data;

   sml_req_if req_if ();
   sml_rsp_if rsp_if ();

   int fail_count;
   int pending_count;
   int checked_count;

   // stimulus bookkeeping
   int          labels_sent      = 0;
   int          sequences_closed = 0;
   int          burst_left       = 0;
   logic [63:0] kernels_used     = '0;
   bit          stall_request    = 1'b0;

   // directed run under the reset kernel of 9: class 3 wins the first window,
   // with an out-of-range label (read as background) and stray classes mixed in
   label_type           majority_run  [12] = '{3, 3, 7, 3, 0, 3, 3, 6, 2, 1, 0, 5};
   logic [KERNEL_W-1:0] phase_kernels [8];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   sliding_majority_label_filter dut (
      .clock          (clock),
      .reset          (reset),
      .req_port       (req_if),
      .rsp_port       (rsp_if),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   sml_label_checker label_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_if),
      .rsp_mon        (rsp_if),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .fail_count     (fail_count),
      .pending_count  (pending_count),
      .checked_count  (checked_count)
   );

   // one label transaction; the sender runs in bursts with random gaps in between,
   // and valid stays high from one label to the next inside a burst
   task automatic send_label(input label_type lab, input logic fin);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      req_if.valid    <= 1'b1;
      req_if.label_in <= lab;
      req_if.last_in  <= fin;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      labels_sent++;
      if (fin) sequences_closed++;
   endtask

   // stop offering and wait until every predicted result has come back;
   // the first edge lets the checker's count catch up with the last transaction
   task automatic wait_drained(input int extra);
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   // kernel writes happen only with the block idle; any open sequence is dropped
   task automatic write_kernel(input logic [KERNEL_W-1:0] value);
      wait_drained(SETTLE_CYCLES);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      kernels_used[value] = 1'b1;
      burst_left = 0;
   endtask

   // one sequence leaning toward a random class, so majorities show up often
   // but not always; noise includes the out-of-range label
   task automatic send_sequence(input int len, input logic closed);
      label_type dominant;
      label_type lab;
      int        bias;
      dominant = label_type'($urandom_range(1, 6));
      bias     = $urandom_range(0, 95);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 99) < bias) lab = dominant;
         else lab = label_type'($urandom_range(0, 7));
         send_label(lab, closed && (i == len - 1));
      end
   endtask

   // receiver: stretches of steady ready, coin-flip stalls and heavy stalls,
   // plus a long hold-off whenever the stimulus asks for one
   initial begin
      int mode;
      int span;
      mode = 0;
      span = 0;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (stall_request) begin
            stall_request = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         if (span == 0) begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(1, 40);
         end
         span--;
         case (mode)
            0: begin
               rsp_if.ready <= 1'b1;
            end
            1: begin
               rsp_if.ready <= 1'($urandom_range(0, 1));
            end
            default: begin
               rsp_if.ready <= ($urandom_range(0, 3) == 0);
            end
         endcase
         @(posedge clock);
      end
   end

   // stimulus and verdict
   initial begin
      int k_eff;
      int budget;
      int phase_items;
      int len;
      bit closed;

      reset           <= 1'b1;
      req_if.valid    <= 1'b0;
      req_if.label_in <= '0;
      req_if.last_in  <= 1'b0;
      csr_write_en    <= 1'b0;
      csr_write_data  <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part, kernel still at its reset value of 9
      // a lone label that closes at once: its flush gives a single zero
      send_label(3'd6, 1'b1);
      // sequence shorter than the window comes out all zero
      for (int i = 1; i <= 5; i++) send_label(label_type'(i), i == 5);
      // full window with a majority, then the flush of the held positions
      foreach (majority_run[i]) send_label(majority_run[i], i == 11);
      // open sequence, abandoned by the kernel write of the first phase
      repeat (3) send_label(3'd4, 1'b0);

      // random phases: kernel zero (acts as one), the smallest windows, the largest,
      // and a few in between; the largest gets more labels so its windows fill
      phase_kernels    = '{0, 1, 2, 3, 6, 63, 12, 5};
      phase_kernels[7] = KERNEL_W'($urandom_range(4, 20));
      foreach (phase_kernels[p]) begin
         k_eff  = (phase_kernels[p] == 0) ? 1 : int'(phase_kernels[p]);
         budget = (k_eff > 32) ? 90 : 30;
         write_kernel(phase_kernels[p]);
         // back the block up while labels keep coming
         if (k_eff == 6 || k_eff == 63) stall_request = 1'b1;
         phase_items = 0;
         while (phase_items < budget) begin
            if ($urandom_range(0, 4) != 0) len = $urandom_range(k_eff, 2 * k_eff + 3);
            else len = $urandom_range(1, k_eff);
            // the phase's final sequence is sometimes left open
            closed = (phase_items + len < budget) || ($urandom_range(0, 2) != 0);
            send_sequence(len, closed);
            phase_items += len;
         end
      end

      wait_drained(DRAIN_CYCLES);

      $display("run covered %0d labels, %0d closed sequences, %0d filtered labels checked",
               labels_sent, sequences_closed, checked_count);
      $display("kernel sizes written: %0d distinct, including 0 and 63",
               $countones(kernels_used));
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // hard limit, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("timeout with %0d filtered labels still outstanding", pending_count);
      $display("== FAIL ==");
      $finish;
   end

endmodule
